FILE: rtl/adcseq_pkg.sv
package adcseq_pkg;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_CONV0 = 2'd1,
		PH_CONV1 = 2'd2
	} phase_t;

	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_DONE = 1'b1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STROBE0_ENABLE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STROBE0_TICKS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STROBE0_ACT_HI  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STROBE1_ENABLE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STROBE1_TICKS   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STROBE1_ACT_HI  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_CH_EN    = 3'd7;

	localparam logic [14:0] SAMPLE_PERIOD_RST = 15'd100;

	typedef struct packed {
		logic [14:0] sample_period;
		logic        s0_en;
		logic [14:0] s0_ticks;
		logic        s0_act_hi;
		logic        s1_en;
		logic [14:0] s1_ticks;
		logic        s1_act_hi;
		logic        ch1_en;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] next_time;
		logic        s0_on;
		logic        s1_on;
		logic [15:0] sample0;
		logic [15:0] sample1;
		logic        pin0;
		logic        pin1;
	} state_t;

	typedef struct packed {
		logic        strobe0_level;
		logic        strobe1_level;
		logic        start_conversion;
		logic        start_channel;
		logic        value_changed;
		logic        changed_channel;
		logic [15:0] sample_value;
	} result_t;

endpackage

FILE: rtl/adcseq_cfg.sv
module adcseq_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [adcseq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [adcseq_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output adcseq_pkg::cfg_t                     cfg
);
	import adcseq_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_period <= SAMPLE_PERIOD_RST;
			cfg_q.s0_en         <= 1'b0;
			cfg_q.s0_ticks      <= '0;
			cfg_q.s0_act_hi     <= 1'b1;
			cfg_q.s1_en         <= 1'b0;
			cfg_q.s1_ticks      <= '0;
			cfg_q.s1_act_hi     <= 1'b1;
			cfg_q.ch1_en        <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLE_PERIOD:  cfg_q.sample_period <= cfg_wdata;
				REG_STROBE0_ENABLE: cfg_q.s0_en         <= cfg_wdata[0];
				REG_STROBE0_TICKS:  cfg_q.s0_ticks      <= cfg_wdata;
				REG_STROBE0_ACT_HI: cfg_q.s0_act_hi     <= cfg_wdata[0];
				REG_STROBE1_ENABLE: cfg_q.s1_en         <= cfg_wdata[0];
				REG_STROBE1_TICKS:  cfg_q.s1_ticks      <= cfg_wdata;
				REG_STROBE1_ACT_HI: cfg_q.s1_act_hi     <= cfg_wdata[0];
				REG_SECOND_CH_EN:   cfg_q.ch1_en        <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/adcseq_step.sv
module adcseq_step (
	input  adcseq_pkg::cfg_t    cfg,
	input  adcseq_pkg::state_t  cur,
	input  logic                func,
	input  logic [15:0]         now,
	input  logic [15:0]         conv_value,
	output adcseq_pkg::state_t  nxt,
	output adcseq_pkg::result_t res
);
	import adcseq_pkg::*;

	logic signed [15:0] left0;
	logic signed [15:0] left1;
	logic signed [15:0] left2;
	logic signed [15:0] ticks0;
	logic signed [15:0] ticks1;
	logic               act0;
	logic               act1;

	assign left0  = $signed(cur.next_time - now);
	assign ticks0 = $signed({1'b0, cfg.s0_ticks});
	assign ticks1 = $signed({1'b0, cfg.s1_ticks});
	// strobe 0 goes active at left <= ticks, strobe 1 only at left < ticks
	assign act0   = cfg.s0_en && (left0 <= ticks0);

	always_comb begin
		nxt   = cur;
		left1 = left0;
		left2 = left0;
		act1  = 1'b0;
		res   = '0;

		if (func == FUNC_TICK) begin
			if (cur.phase == PH_IDLE) begin
				if (act0) begin
					nxt.pin0 = cfg.s0_act_hi;
					if (!cur.s0_on) begin
						left1     = ticks0;
						nxt.s0_on = 1'b1;
					end
				end else begin
					nxt.pin0  = ~cfg.s0_act_hi;
					nxt.s0_on = 1'b0;
				end

				left2 = left1;
				act1  = cfg.s1_en && (left1 < ticks1);
				if (act1) begin
					nxt.pin1 = cfg.s1_act_hi;
					if (!cur.s1_on) begin
						left2     = ticks1;
						nxt.s1_on = 1'b1;
					end
				end else begin
					nxt.pin1  = ~cfg.s1_act_hi;
					nxt.s1_on = 1'b0;
				end

				if (left2[15]) begin
					res.start_conversion = 1'b1;
					res.start_channel    = 1'b0;
					nxt.phase            = PH_CONV0;
					nxt.next_time        = now + {1'b0, cfg.sample_period};
				end
			end
		end else begin
			unique case (cur.phase)
				PH_IDLE: ;
				PH_CONV0: begin
					if (conv_value != cur.sample0) begin
						nxt.sample0         = conv_value;
						res.value_changed   = 1'b1;
						res.changed_channel = 1'b0;
						res.sample_value    = conv_value;
					end
					if (cfg.ch1_en) begin
						res.start_conversion = 1'b1;
						res.start_channel    = 1'b1;
						nxt.phase            = PH_CONV1;
					end else begin
						nxt.phase = PH_IDLE;
					end
				end
				default: begin
					if (conv_value != cur.sample1) begin
						nxt.sample1         = conv_value;
						res.value_changed   = 1'b1;
						res.changed_channel = 1'b1;
						res.sample_value    = conv_value;
					end
					nxt.phase = PH_IDLE;
				end
			endcase
		end

		res.strobe0_level = nxt.pin0;
		res.strobe1_level = nxt.pin1;
	end

endmodule

FILE: rtl/periodic_two_channel_adc_sequencer_core.sv
// Periodic two-channel ADC sequencer. Each input transaction is either a timer
// tick carrying the current 16-bit time or a conversion-done event with the
// converter result; each produces exactly one result transaction with the strobe
// pin levels, a conversion start request and, when a stored sample changed, the
// new value. Throughput is one transaction per clock while out_ready is high;
// each passes an input register, then the subtract/compare result register.
// The result register frees itself as it is read, so input is taken while a
// result waits. Configuration registers are written through cfg_we/cfg_index/
// cfg_wdata and must only change while no transaction is in flight.
module periodic_two_channel_adc_sequencer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [adcseq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [adcseq_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic [15:0]                       now,
	input  logic [15:0]                       conv_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              strobe0_level,
	output logic                              strobe1_level,
	output logic                              start_conversion,
	output logic                              start_channel,
	output logic                              value_changed,
	output logic                              changed_channel,
	output logic [15:0]                       sample_value
);
	import adcseq_pkg::*;

	cfg_t        cfg;
	state_t      state_q;
	state_t      state_nxt;
	result_t     res_nxt;
	result_t     res_q;
	logic        out_valid_q;
	logic        valid_s1;
	logic        func_s1;
	logic [15:0] now_s1;
	logic [15:0] conv_value_s1;
	logic        advance;

	adcseq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// stage 1 moves into the result register when that one is empty or being read
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1       <= func;
			now_s1        <= now;
			conv_value_s1 <= conv_value;
		end
	end

	adcseq_step u_step (
		.cfg        (cfg),
		.cur        (state_q),
		.func       (func_s1),
		.now        (now_s1),
		.conv_value (conv_value_s1),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase     <= PH_IDLE;
			state_q.next_time <= '0;
			state_q.s0_on     <= 1'b0;
			state_q.s1_on     <= 1'b0;
			state_q.sample0   <= '0;
			state_q.sample1   <= '0;
			state_q.pin0      <= 1'b0;
			state_q.pin1      <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid        = out_valid_q;
	assign strobe0_level    = res_q.strobe0_level;
	assign strobe1_level    = res_q.strobe1_level;
	assign start_conversion = res_q.start_conversion;
	assign start_channel    = res_q.start_channel;
	assign value_changed    = res_q.value_changed;
	assign changed_channel  = res_q.changed_channel;
	assign sample_value     = res_q.sample_value;

endmodule
